// File: rtl/scrd_pkg.sv
// Shared types, constants and register codes of the scan-line colour-run detector.
package scrd_pkg;

  localparam int LINE_MAX    = 4096;
  localparam int STAR_PAIRS  = 2;
  localparam int STRIPE_RUNS = 4;
  localparam int STAR_WINDOW = 2 * STAR_PAIRS;

  localparam int CHAN_W  = 8;
  localparam int POS_W   = 12;
  localparam int RATIO_W = 4;
  localparam int PROD_W  = POS_W + RATIO_W;

  localparam int EVQ_DEPTH  = 4;
  localparam int EVQ_AW     = $clog2(EVQ_DEPTH);
  localparam int RESQ_DEPTH = 2;
  localparam int RESQ_AW    = $clog2(RESQ_DEPTH);

  localparam int CFG_AW = 5;

  localparam logic [2:0] REG_WHITE_LEVEL     = 3'd0;
  localparam logic [2:0] REG_RED_LEVEL       = 3'd1;
  localparam logic [2:0] REG_RED_OTHER_MAX   = 3'd2;
  localparam logic [2:0] REG_BLUE_DARK_LEVEL = 3'd3;
  localparam logic [2:0] REG_BLACK_LEVEL     = 3'd4;
  localparam logic [2:0] REG_STAR_RATIO      = 3'd5;
  localparam logic [2:0] REG_STRIPE_RATIO    = 3'd6;
  localparam logic [2:0] REG_SCAN_COLUMNS    = 3'd7;

  typedef enum logic [1:0] {
    CLS_WHITE = 2'd0,
    CLS_RED   = 2'd1,
    CLS_BLUE  = 2'd2,
    CLS_OTHER = 2'd3
  } class_t;

  typedef struct packed {
    logic [CHAN_W-1:0] white_level;
    logic [CHAN_W-1:0] red_level;
    logic [CHAN_W-1:0] red_other_max;
    logic [CHAN_W-1:0] blue_dark_level;
    logic [CHAN_W-1:0] black_level;
    logic              scan_columns;
  } cls_cfg_t;

  typedef struct packed {
    logic clear;
    logic push;
  } win_op_t;

  typedef struct packed {
    win_op_t          star;
    win_op_t          stripe;
    logic [POS_W-1:0] len;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
  } evt_t;

  typedef struct packed {
    logic             star_found;
    logic [POS_W-1:0] star_scale;
    logic             stripe_found;
    logic [POS_W-1:0] stripe_scale;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
  } res_t;

endpackage

// File: rtl/scrd_front.sv
// Front end: classifies each pixel, measures runs and emits window operations.
module scrd_front import scrd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [CHAN_W-1:0] blue,
  input  logic [CHAN_W-1:0] green,
  input  logic [CHAN_W-1:0] red,
  input  logic [POS_W-1:0]  line_index,
  input  logic [POS_W-1:0]  pixel_index,
  input  cls_cfg_t          cfg,
  output evt_t              evt
);

  class_t           prev_class;
  logic [POS_W-1:0] run_start;

  class_t           cur;
  class_t           prev_eff;
  logic [POS_W-1:0] start_eff;
  logic [POS_W-1:0] diff;
  logic             new_line;
  logic             changed;
  logic             cur_wb, prev_wb, cur_wr, prev_wr;

  always_comb begin
    if (blue > cfg.white_level && green > cfg.white_level && red > cfg.white_level) begin
      cur = CLS_WHITE;
    end else if (blue < cfg.red_other_max && green < cfg.red_other_max &&
                 red > cfg.red_level) begin
      cur = CLS_RED;
    end else if ((blue > green && blue > red && blue < cfg.blue_dark_level) ||
                 (blue < cfg.black_level && green < cfg.black_level &&
                  red < cfg.black_level)) begin
      cur = CLS_BLUE;
    end else begin
      cur = CLS_OTHER;
    end
  end

  always_comb begin
    new_line  = (pixel_index == '0);
    prev_eff  = new_line ? CLS_OTHER : prev_class;
    start_eff = new_line ? '0 : run_start;
    changed   = (cur != prev_eff);
    cur_wb    = (cur == CLS_WHITE) || (cur == CLS_BLUE);
    prev_wb   = (prev_eff == CLS_WHITE) || (prev_eff == CLS_BLUE);
    cur_wr    = (cur == CLS_WHITE) || (cur == CLS_RED);
    prev_wr   = (prev_eff == CLS_WHITE) || (prev_eff == CLS_RED);

    diff = (pixel_index >= start_eff) ? (pixel_index - start_eff) : '0;
    if (int'(diff) > LINE_MAX - 1) begin
      diff = POS_W'(LINE_MAX - 1);
    end

    evt.star.clear   = new_line || (changed && cur_wb && !prev_wb);
    evt.star.push    = changed && cur_wb && prev_wb;
    evt.stripe.clear = new_line || (changed && cur_wr && !prev_wr);
    evt.stripe.push  = changed && cur_wr && prev_wr;
    evt.len          = diff;
    evt.row          = cfg.scan_columns ? pixel_index : line_index;
    evt.column       = cfg.scan_columns ? line_index : pixel_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_class <= CLS_OTHER;
      run_start  <= '0;
    end else if (accept) begin
      prev_class <= cur;
      if (changed) begin
        run_start <= pixel_index;
      end else begin
        run_start <= start_eff;
      end
    end
  end

endmodule

// File: rtl/scrd_evq.sv
// Short event queue between the front and back ends.
module scrd_evq import scrd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  evt_t wr_data,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output evt_t rd_data
);

  evt_t              slots [EVQ_DEPTH];
  logic [EVQ_AW-1:0] wr_ptr;
  logic [EVQ_AW-1:0] rd_ptr;
  logic [EVQ_AW:0]   count;

  assign full     = (count == (EVQ_AW+1)'(EVQ_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/scrd_back.sv
// Back end: run windows, ratio checks and the result queue.
module scrd_back import scrd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               evt_valid,
  input  evt_t               evt,
  output logic               evt_take,
  input  logic [RATIO_W-1:0] star_ratio,
  input  logic [RATIO_W-1:0] stripe_ratio,
  input  logic               res_pop,
  output logic               res_empty,
  output res_t               res
);

  localparam int STAR_KEEP   = STAR_WINDOW - 1;
  localparam int STRIPE_KEEP = STRIPE_RUNS - 1;
  localparam int STAR_CW     = $clog2(STAR_WINDOW);
  localparam int STRIPE_CW   = $clog2(STRIPE_RUNS);

  // Only the runs before the last one of a full window are held; the
  // newest length joins the check straight from the event.
  logic [POS_W-1:0]     star_runs [STAR_KEEP];
  logic [STAR_CW-1:0]   star_cnt;
  logic [POS_W-1:0]     stripe_runs [STRIPE_KEEP];
  logic [STRIPE_CW-1:0] stripe_cnt;

  logic [POS_W-1:0]     star_runs_next [STAR_KEEP];
  logic [STAR_CW-1:0]   star_cnt_next;
  logic [POS_W-1:0]     stripe_runs_next [STRIPE_KEEP];
  logic [STRIPE_CW-1:0] stripe_cnt_next;

  logic [STAR_CW-1:0]   star_base;
  logic [STRIPE_CW-1:0] stripe_base;
  logic                 star_full, stripe_full;
  logic [POS_W-1:0]     star_mn, star_mx, stripe_mn, stripe_mx;
  logic                 star_match, stripe_match;
  res_t                 res_new;

  res_t                   resq [RESQ_DEPTH];
  logic [RESQ_AW-1:0]     resq_wr;
  logic [RESQ_AW-1:0]     resq_rd;
  logic [RESQ_AW:0]       resq_cnt;
  logic                   pop_ok;

  assign pop_ok    = res_pop && !res_empty;
  assign res_empty = (resq_cnt == '0);
  assign res       = resq[resq_rd];
  assign evt_take  = evt_valid &&
                     ((resq_cnt != (RESQ_AW+1)'(RESQ_DEPTH)) || pop_ok);

  // Star window.
  always_comb begin
    star_base = evt.star.clear ? '0 : star_cnt;
    star_full = (star_base == STAR_CW'(STAR_WINDOW - 1));
    star_mn   = evt.len;
    star_mx   = evt.len;
    for (int i = 0; i < STAR_KEEP; i++) begin
      if (star_runs[i] < star_mn) star_mn = star_runs[i];
      if (star_runs[i] > star_mx) star_mx = star_runs[i];
    end
    star_match = evt.star.push && star_full &&
                 (PROD_W'(star_mx) <= PROD_W'(star_ratio) * PROD_W'(star_mn));
    star_runs_next = star_runs;
    star_cnt_next  = star_base;
    if (evt.star.push) begin
      if (!star_full) begin
        for (int i = 0; i < STAR_KEEP; i++) begin
          if (STAR_CW'(i) == star_base) star_runs_next[i] = evt.len;
        end
        star_cnt_next = star_base + 1'b1;
      end else if (star_match) begin
        star_cnt_next = '0;
      end else begin
        for (int i = 0; i < STAR_KEEP - 1; i++) begin
          star_runs_next[i] = star_runs[i+1];
        end
        star_runs_next[STAR_KEEP-1] = evt.len;
      end
    end
  end

  // Stripe window.
  always_comb begin
    stripe_base = evt.stripe.clear ? '0 : stripe_cnt;
    stripe_full = (stripe_base == STRIPE_CW'(STRIPE_RUNS - 1));
    stripe_mn   = evt.len;
    stripe_mx   = evt.len;
    for (int i = 0; i < STRIPE_KEEP; i++) begin
      if (stripe_runs[i] < stripe_mn) stripe_mn = stripe_runs[i];
      if (stripe_runs[i] > stripe_mx) stripe_mx = stripe_runs[i];
    end
    stripe_match = evt.stripe.push && stripe_full &&
                   (PROD_W'(stripe_mx) <= PROD_W'(stripe_ratio) * PROD_W'(stripe_mn));
    stripe_runs_next = stripe_runs;
    stripe_cnt_next  = stripe_base;
    if (evt.stripe.push) begin
      if (!stripe_full) begin
        for (int i = 0; i < STRIPE_KEEP; i++) begin
          if (STRIPE_CW'(i) == stripe_base) stripe_runs_next[i] = evt.len;
        end
        stripe_cnt_next = stripe_base + 1'b1;
      end else if (stripe_match) begin
        stripe_cnt_next = '0;
      end else begin
        for (int i = 0; i < STRIPE_KEEP - 1; i++) begin
          stripe_runs_next[i] = stripe_runs[i+1];
        end
        stripe_runs_next[STRIPE_KEEP-1] = evt.len;
      end
    end
  end

  always_comb begin
    res_new.star_found   = star_match;
    res_new.star_scale   = star_match ? star_mx : '0;
    res_new.stripe_found = stripe_match;
    res_new.stripe_scale = stripe_match ? stripe_mx : '0;
    res_new.row          = evt.row;
    res_new.column       = evt.column;
  end

  always_ff @(posedge clk) begin
    if (evt_take) begin
      star_runs        <= star_runs_next;
      stripe_runs      <= stripe_runs_next;
      resq[resq_wr]    <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      star_cnt   <= '0;
      stripe_cnt <= '0;
      resq_wr    <= '0;
      resq_rd    <= '0;
      resq_cnt   <= '0;
    end else begin
      if (evt_take) begin
        star_cnt   <= star_cnt_next;
        stripe_cnt <= stripe_cnt_next;
        resq_wr    <= resq_wr + 1'b1;
      end
      if (pop_ok) begin
        resq_rd <= resq_rd + 1'b1;
      end
      if (evt_take && !pop_ok) begin
        resq_cnt <= resq_cnt + 1'b1;
      end else if (pop_ok && !evt_take) begin
        resq_cnt <= resq_cnt - 1'b1;
      end
    end
  end

endmodule

// File: rtl/scanline_color_run_pattern_detector_top.sv
// Top level of the scan-line colour-run pattern detector with its register file.
// The detector takes one pixel item per clock while full is low and returns one
// result item per pixel, in order. An item is classified at once in the front
// end, which keeps the previous colour class and the start of the current run,
// and on acceptance is written as an event into a four-entry queue; the back
// end takes the oldest event while the result queue has room or is popped,
// updates the star and stripe windows and checks max against ratio times min,
// and writes the result into a two-entry result queue, from which it is shown
// on the output ports and can be popped. The sustained rate is one item per
// cycle while neither queue stalls, set by the front-end state loop (class and
// run start) and the window update in the back end. The two queues let either
// side stall on its own: full rises only once the event queue holds four
// items, and empty falls as soon as a result waits.
// A pixel index of zero starts a new line and empties both windows.
// Configuration registers lie at byte addresses 4*i and must only be written
// while no item is in flight.
module scanline_color_run_pattern_detector_top import scrd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // pixel items
  input  logic              push,
  output logic              full,
  input  logic [CHAN_W-1:0] blue,
  input  logic [CHAN_W-1:0] green,
  input  logic [CHAN_W-1:0] red,
  input  logic [POS_W-1:0]  line_index,
  input  logic [POS_W-1:0]  pixel_index,
  // result items
  output logic              empty,
  input  logic              pop,
  output logic              star_found,
  output logic [POS_W-1:0]  star_scale,
  output logic              stripe_found,
  output logic [POS_W-1:0]  stripe_scale,
  output logic [POS_W-1:0]  row,
  output logic [POS_W-1:0]  column,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cls_cfg_t           cls_cfg;
  logic [RATIO_W-1:0] star_ratio;
  logic [RATIO_W-1:0] stripe_ratio;
  logic               cfg_wr;
  logic [2:0]         reg_sel;

  logic               in_accept;
  evt_t               front_evt;
  evt_t               back_evt;
  logic               evq_valid;
  logic               evq_take;
  res_t               res;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign reg_sel   = paddr[CFG_AW-1:2];
  assign in_accept = push && !full;

  // Register file: every register index of the address range exists.
  always_ff @(posedge clk) begin
    if (rst) begin
      cls_cfg.white_level     <= 8'd100;
      cls_cfg.red_level       <= 8'd130;
      cls_cfg.red_other_max   <= 8'd100;
      cls_cfg.blue_dark_level <= 8'd110;
      cls_cfg.black_level     <= 8'd25;
      cls_cfg.scan_columns    <= 1'b0;
      star_ratio              <= 4'd2;
      stripe_ratio            <= 4'd2;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_WHITE_LEVEL:     cls_cfg.white_level     <= pwdata[CHAN_W-1:0];
        REG_RED_LEVEL:       cls_cfg.red_level       <= pwdata[CHAN_W-1:0];
        REG_RED_OTHER_MAX:   cls_cfg.red_other_max   <= pwdata[CHAN_W-1:0];
        REG_BLUE_DARK_LEVEL: cls_cfg.blue_dark_level <= pwdata[CHAN_W-1:0];
        REG_BLACK_LEVEL:     cls_cfg.black_level     <= pwdata[CHAN_W-1:0];
        REG_STAR_RATIO:      star_ratio              <= pwdata[RATIO_W-1:0];
        REG_STRIPE_RATIO:    stripe_ratio            <= pwdata[RATIO_W-1:0];
        REG_SCAN_COLUMNS:    cls_cfg.scan_columns    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WHITE_LEVEL:     prdata = 32'(cls_cfg.white_level);
      REG_RED_LEVEL:       prdata = 32'(cls_cfg.red_level);
      REG_RED_OTHER_MAX:   prdata = 32'(cls_cfg.red_other_max);
      REG_BLUE_DARK_LEVEL: prdata = 32'(cls_cfg.blue_dark_level);
      REG_BLACK_LEVEL:     prdata = 32'(cls_cfg.black_level);
      REG_STAR_RATIO:      prdata = 32'(star_ratio);
      REG_STRIPE_RATIO:    prdata = 32'(stripe_ratio);
      REG_SCAN_COLUMNS:    prdata = 32'(cls_cfg.scan_columns);
      default:             prdata = '0;
    endcase
  end

  scrd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .blue        (blue),
    .green       (green),
    .red         (red),
    .line_index  (line_index),
    .pixel_index (pixel_index),
    .cfg         (cls_cfg),
    .evt         (front_evt)
  );

  scrd_evq u_evq (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (in_accept),
    .wr_data  (front_evt),
    .full     (full),
    .rd_en    (evq_take),
    .rd_valid (evq_valid),
    .rd_data  (back_evt)
  );

  scrd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .evt_valid    (evq_valid),
    .evt          (back_evt),
    .evt_take     (evq_take),
    .star_ratio   (star_ratio),
    .stripe_ratio (stripe_ratio),
    .res_pop      (pop),
    .res_empty    (empty),
    .res          (res)
  );

  assign star_found   = res.star_found;
  assign star_scale   = res.star_scale;
  assign stripe_found = res.stripe_found;
  assign stripe_scale = res.stripe_scale;
  assign row          = res.row;
  assign column       = res.column;

  // Both queues come out of reset empty, so nothing is shown and input is open.
  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // While the star window did not match, no unmatched window reports a scale.
  a_scale_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !star_found) |-> (star_scale == '0 && (stripe_found || stripe_scale == '0)))
    else $error("scale reported without a match");

  // The event queue can only fill up through an accepted item.
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("event queue filled without an accepted item");

endmodule
